FILE: hdl/pfe_pkg.sv
// pfe_pkg: shared types, codes and decode helpers for the postfix evaluator
// no dependencies; imported by pfe_alu, pfe_stack and postfix_expression_evaluator
package pfe_pkg;

  // default operand stack depth
  localparam int STACK_DEPTH_DEF = 16;

  // data word width
  localparam int WORD_W = 32;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DIVZERO   = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_ZEROZERO  = 3'd4;

  // ascii codes of interest
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ADD  = 8'h2b;
  localparam logic [7:0] CH_SUB  = 8'h2d;
  localparam logic [7:0] CH_MUL  = 8'h2a;
  localparam logic [7:0] CH_DIV  = 8'h2f;
  localparam logic [7:0] CH_MOD  = 8'h25;
  localparam logic [7:0] CH_POW  = 8'h5e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_POW
  } op_t;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_L,
    S_EXEC,
    S_WAIT,
    S_FIN,
    S_TOP
  } seq_state_t;

  // states of the arithmetic unit
  typedef enum logic [2:0] {
    A_IDLE,
    A_DIV,
    A_FIX,
    A_POW_MUL,
    A_POW_SQR
  } alu_state_t;

  // request into the arithmetic unit
  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  // response from the arithmetic unit
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
    logic [2:0]        err;
  } alu_rsp_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_ADD) || (c == CH_SUB) || (c == CH_MUL) ||
           (c == CH_DIV) || (c == CH_MOD) || (c == CH_POW);
  endfunction

  function automatic op_t op_of(input logic [7:0] c);
    op_t o;
    unique case (c)
      CH_ADD:  o = OP_ADD;
      CH_SUB:  o = OP_SUB;
      CH_MUL:  o = OP_MUL;
      CH_DIV:  o = OP_DIV;
      CH_MOD:  o = OP_MOD;
      CH_POW:  o = OP_POW;
      default: o = OP_ADD;
    endcase
    return o;
  endfunction

endpackage

FILE: hdl/postfix_expression_evaluator.sv
// postfix_expression_evaluator: top level, sequencer around the operand stack
// and the shared arithmetic unit; depends on pfe_pkg, pfe_stack, pfe_alu
//
// channel  direction  ports                       beat
// in       input      in_symbol, in_last          one character of the expression
// out      output     out_value, out_status       top of stack and first error
//
// one beat at a time: digits and ignored characters bypass the ALU, + - * and
// divide by zero answer directly, / and % use a 32-step restoring divider, ^ makes
// a multiply and a squaring pass per exponent bit; a last beat adds a result step
// rst_n is synchronous and clears stack count, error record and output valid
// the result waits in an output register; a new beat is taken while it waits,
// and only the next result stalls until out_ready frees the register
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_symbol,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pfe_pkg::WORD_W-1:0] out_value,
  output logic [2:0]                 out_status
);
  import pfe_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  seq_state_t        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [2:0]        err_r, err_nxt;
  logic              last_r, last_nxt;
  op_t               op_r, op_nxt;
  logic [WORD_W-1:0] rhs_r, rhs_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;
  logic [2:0]        out_status_r, out_status_nxt;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data, rd_data;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              accept;
  logic              slot_free;
  logic [3:0]        digit;
  logic [CW-1:0]     cnt_m1;
  logic [AW-1:0]     cnt_m2;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign digit     = 4'(in_symbol - CH_ZERO);
  assign cnt_m1    = cnt_r - CW'(1);
  assign cnt_m2    = cnt_r[AW-1:0] - AW'(2);

  pfe_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pfe_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .lhs   (rd_data),
    .rhs   (rhs_r),
    .rsp   (alu_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_op(in_symbol) && (cnt_r >= CW'(2))) state_nxt = S_RD_L;
          else                                       state_nxt = S_FIN;
        end
      end
      S_RD_L: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_WAIT;
      S_WAIT: begin
        if (alu_rsp.done) state_nxt = S_FIN;
      end
      S_FIN:  state_nxt = last_r ? S_TOP : S_IDLE;
      S_TOP: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = cnt_r[AW-1:0];
    wr_data        = {{(WORD_W-4){1'b0}}, digit};
    rd_en          = 1'b0;
    rd_addr        = cnt_m1[AW-1:0];
    alu_req.start  = 1'b0;
    alu_req.op     = op_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    last_nxt       = last_r;
    op_nxt         = op_r;
    rhs_nxt        = rhs_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_last;
          op_nxt   = op_of(in_symbol);
          if (is_digit(in_symbol)) begin
            if (cnt_r >= CW'(STACK_DEPTH)) begin
              if (err_r == ST_OK) err_nxt = ST_OVERFLOW;
            end else begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end else if (is_op(in_symbol)) begin
            if (cnt_r < CW'(2)) begin
              if (err_r == ST_OK) err_nxt = ST_UNDERFLOW;
            end else begin
              // fetch right operand
              rd_en   = 1'b1;
              rd_addr = cnt_m1[AW-1:0];
            end
          end
        end
      end
      S_RD_L: begin
        // hold right operand, fetch left operand
        rhs_nxt = rd_data;
        rd_en   = 1'b1;
        rd_addr = cnt_m2[AW-1:0];
      end
      S_EXEC: begin
        alu_req.start = 1'b1;
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          wr_en   = 1'b1;
          wr_addr = cnt_m2[AW-1:0];
          wr_data = alu_rsp.result;
          cnt_nxt = cnt_m1;
          if ((err_r == ST_OK) && (alu_rsp.err != ST_OK)) err_nxt = alu_rsp.err;
        end
      end
      S_FIN: begin
        // fetch top of stack for the result beat
        if (last_r && (cnt_r != '0)) begin
          rd_en   = 1'b1;
          rd_addr = cnt_m1[AW-1:0];
        end
      end
      S_TOP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (cnt_r == '0) begin
            out_value_nxt  = '0;
            out_status_nxt = (err_r == ST_OK) ? ST_UNDERFLOW : err_r;
          end else begin
            out_value_nxt  = rd_data;
            out_status_nxt = err_r;
          end
          cnt_nxt = '0;
          err_nxt = ST_OK;
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r       <= last_nxt;
    op_r         <= op_nxt;
    rhs_r        <= rhs_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

FILE: hdl/pfe_stack.sv
// pfe_stack: operand stack storage, one write port and one registered read port
// depends on pfe_pkg for the word width
module pfe_stack #(
  parameter int DEPTH = pfe_pkg::STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [pfe_pkg::WORD_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [pfe_pkg::WORD_W-1:0] rd_data
);
  import pfe_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/pfe_alu.sv
// pfe_alu: shared arithmetic unit, add/sub/mul in one step, restoring divide
// over 32 steps, power by square-and-multiply on one shared multiplier; uses pfe_pkg
module pfe_alu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pfe_pkg::alu_req_t          req,
  input  logic [pfe_pkg::WORD_W-1:0] lhs,
  input  logic [pfe_pkg::WORD_W-1:0] rhs,
  output pfe_pkg::alu_rsp_t          rsp
);
  import pfe_pkg::*;

  alu_state_t        st_r, st_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] aux_r, aux_nxt;
  logic [WORD_W-2:0] exp_r, exp_nxt;
  logic [4:0]        step_r, step_nxt;
  op_t               op_r, op_nxt;
  logic              negq_r, negq_nxt;
  logic              negr_r, negr_nxt;
  logic              done_r, done_nxt;
  logic [2:0]        err_r, err_nxt;

  logic [WORD_W-1:0] mul_a, mul_b, mul_p;
  logic [WORD_W-1:0] abs_l, abs_r;
  logic [WORD_W:0]   rem_sh, diff;

  // operand magnitudes for the divider
  assign abs_l = lhs[WORD_W-1] ? (~lhs + 1'b1) : lhs;
  assign abs_r = rhs[WORD_W-1] ? (~rhs + 1'b1) : rhs;

  // shared multiplier, low word of the product
  always_comb begin
    unique case (st_r)
      A_POW_MUL: begin
        mul_a = acc_r;
        mul_b = aux_r;
      end
      A_POW_SQR: begin
        mul_a = aux_r;
        mul_b = aux_r;
      end
      default: begin
        mul_a = lhs;
        mul_b = rhs;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one restoring divide step
  assign rem_sh = {rem_r, acc_r[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, aux_r};

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            OP_DIV, OP_MOD: begin
              if (rhs != '0) st_nxt = A_DIV;
            end
            OP_POW: begin
              if (!rhs[WORD_W-1] && (rhs != '0)) st_nxt = A_POW_MUL;
            end
            default: st_nxt = A_IDLE;
          endcase
        end
      end
      A_DIV: begin
        if (step_r == 5'd31) st_nxt = A_FIX;
      end
      A_FIX:     st_nxt = A_IDLE;
      A_POW_MUL: st_nxt = (exp_r == '0) ? A_IDLE : A_POW_SQR;
      A_POW_SQR: st_nxt = A_POW_MUL;
      default:   st_nxt = A_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    aux_nxt  = aux_r;
    exp_nxt  = exp_r;
    step_nxt = step_r;
    op_nxt   = op_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    err_nxt  = err_r;
    done_nxt = 1'b0;
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          err_nxt = ST_OK;
          op_nxt  = req.op;
          unique case (req.op)
            OP_ADD: begin
              acc_nxt  = lhs + rhs;
              done_nxt = 1'b1;
            end
            OP_SUB: begin
              acc_nxt  = lhs - rhs;
              done_nxt = 1'b1;
            end
            OP_MUL: begin
              acc_nxt  = mul_p;
              done_nxt = 1'b1;
            end
            OP_DIV, OP_MOD: begin
              if (rhs == '0) begin
                acc_nxt  = '0;
                err_nxt  = ST_DIVZERO;
                done_nxt = 1'b1;
              end else begin
                acc_nxt  = abs_l;
                aux_nxt  = abs_r;
                rem_nxt  = '0;
                step_nxt = '0;
                negq_nxt = lhs[WORD_W-1] ^ rhs[WORD_W-1];
                negr_nxt = lhs[WORD_W-1];
              end
            end
            OP_POW: begin
              acc_nxt = WORD_W'(1);
              if ((lhs == '0) && (rhs == '0)) begin
                err_nxt  = ST_ZEROZERO;
                done_nxt = 1'b1;
              end else if (rhs[WORD_W-1] || (rhs == '0)) begin
                done_nxt = 1'b1;
              end else begin
                aux_nxt = lhs;
                exp_nxt = rhs[WORD_W-2:0];
              end
            end
            default: done_nxt = 1'b1;
          endcase
        end
      end
      A_DIV: begin
        // partial remainder stays below the divisor, so it fits one word
        step_nxt = step_r + 5'd1;
        if (!diff[WORD_W]) begin
          rem_nxt = diff[WORD_W-1:0];
          acc_nxt = {acc_r[WORD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[WORD_W-1:0];
          acc_nxt = {acc_r[WORD_W-2:0], 1'b0};
        end
      end
      A_FIX: begin
        done_nxt = 1'b1;
        if (op_r == OP_DIV) begin
          acc_nxt = negq_r ? (~acc_r + 1'b1) : acc_r;
        end else begin
          acc_nxt = negr_r ? (~rem_r[WORD_W-1:0] + 1'b1) : rem_r[WORD_W-1:0];
        end
      end
      A_POW_MUL: begin
        if (exp_r == '0) begin
          done_nxt = 1'b1;
        end else if (exp_r[0]) begin
          acc_nxt = mul_p;
        end
      end
      A_POW_SQR: begin
        aux_nxt = mul_p;
        exp_nxt = exp_r >> 1;
      end
      default: done_nxt = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    aux_r  <= aux_nxt;
    exp_r  <= exp_nxt;
    step_r <= step_nxt;
    op_r   <= op_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
    err_r  <= err_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;
  assign rsp.err    = err_r;

endmodule
